### sv/lfu_pkg.sv
// lfu_pkg: shared types and constants of the lfu cache table
// entry layout, opcodes, sequencer states and compare-unit result
// no dependencies
package lfu_pkg;

  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 32;
  localparam int STAMP_W = 48;
  localparam int CFG_W   = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   CAP_RESET = 5'd16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // one stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VAL_W-1:0]   value;
    logic [COUNT_W-1:0] count;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

  // result of the shared compare unit
  typedef struct packed {
    logic key_eq;
    logic less;
  } cmp_res_t;

endpackage

### sv/lfu_if.sv
// lfu_if: valid/ready channel interfaces of the lfu cache table
// request, result and configuration channels
// depends on lfu_pkg
interface lfu_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [lfu_pkg::KEY_W-1:0] key;
  logic [lfu_pkg::VAL_W-1:0] value;

  modport source (output valid, output op, output key, output value, input ready);
  modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lfu_out_if;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic [lfu_pkg::VAL_W-1:0] read_value;
  logic                      evicted;
  logic [lfu_pkg::KEY_W-1:0] evicted_key;

  modport source (output valid, output hit, output read_value, output evicted,
                  output evicted_key, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted,
                  input evicted_key, output ready);
endinterface

interface lfu_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [lfu_pkg::CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/lfu_ram.sv
// lfu_ram: generic single-write, single-read ram with registered read
// no dependencies
module lfu_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/lfu_cmp.sv
// lfu_cmp: shared compare unit, key match and victim ranking
// rank is {count, stamp}; lower rank means better eviction candidate
// depends on lfu_pkg
module lfu_cmp (
  input  logic [lfu_pkg::KEY_W-1:0]                   ent_key,
  input  logic [lfu_pkg::KEY_W-1:0]                   req_key,
  input  logic [lfu_pkg::COUNT_W+lfu_pkg::STAMP_W-1:0] ent_rank,
  input  logic [lfu_pkg::COUNT_W+lfu_pkg::STAMP_W-1:0] best_rank,
  output lfu_pkg::cmp_res_t                           res
);

  // key equality and strict lexicographic less-than on count then stamp
  always_comb begin
    res.key_eq = (ent_key == req_key);
    res.less   = (ent_rank < best_rank);
  end

endmodule

### sv/lfu_cache_table_top.sv
// lfu_cache_table_top: lfu key-value table with lru tie-break, scan sequencer
// depends on lfu_pkg, lfu_if, lfu_ram, lfu_cmp
//
// Usage:
//   in_ch  : request transactions {op, key, value}; op get looks up, op put
//            inserts or updates. ready is high only while the sequencer idles.
//   out_ch : one result transaction per request {hit, read_value, evicted,
//            evicted_key}, held in an output register until taken.
//   cfg_ch : writes capacity_in_use (5 bits, reset 16, clamped to CAPACITY);
//            always ready, write only while no request is in flight.
// Timing: an accepted request goes through the scan state, one entry read
//   per cycle from the entry ram through the shared compare unit, then the
//   write-back state, which holds while out_ch stalls. A new request is
//   accepted only in idle, after write-back of the previous one, since the
//   scan occupies the single ram read port.
// Reset: rst_n (synchronous, active low) clears valid bits, occupancy, the
//   touch counter and the sequencer; no clearing pass, ready right away.
// Stall: a finished result waits in the write-back cycle while the previous
//   result is still held by out_ch, so nothing is lost or overwritten.
module lfu_cache_table_top #(
  parameter int CAPACITY = 16
) (
  input logic clk,
  input logic rst_n,
  lfu_in_if.sink    in_ch,
  lfu_out_if.source out_ch,
  lfu_cfg_if.sink   cfg_ch
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CW     = (CNT_W > lfu_pkg::CFG_W) ? CNT_W : lfu_pkg::CFG_W;
  localparam int RANK_W = lfu_pkg::COUNT_W + lfu_pkg::STAMP_W;
  localparam int ENT_W  = $bits(lfu_pkg::entry_t);

  lfu_pkg::state_t state_r, state_nxt;

  // request latches
  logic                        op_r, op_nxt;
  logic [lfu_pkg::KEY_W-1:0]   key_r, key_nxt;
  logic [lfu_pkg::VAL_W-1:0]   val_r, val_nxt;

  // scan state
  logic [CNT_W-1:0]            scan_cnt_r, scan_cnt_nxt;
  logic                        rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]            rd_idx_r, rd_idx_nxt;

  // hit record
  logic                        found_r, found_nxt;
  logic [IDX_W-1:0]            hit_idx_r, hit_idx_nxt;
  logic [lfu_pkg::VAL_W-1:0]   hit_val_r, hit_val_nxt;
  logic [lfu_pkg::COUNT_W-1:0] hit_cnt_r, hit_cnt_nxt;

  // victim record
  logic                        have_vic_r, have_vic_nxt;
  logic [IDX_W-1:0]            vic_idx_r, vic_idx_nxt;
  logic [RANK_W-1:0]           vic_rank_r, vic_rank_nxt;
  logic [lfu_pkg::KEY_W-1:0]   vic_key_r, vic_key_nxt;

  // free slot record
  logic                        free_have_r, free_have_nxt;
  logic [IDX_W-1:0]            free_idx_r, free_idx_nxt;

  // table state
  logic [CAPACITY-1:0]         vld_r, vld_nxt;
  logic [CNT_W-1:0]            occ_r, occ_nxt;
  logic [lfu_pkg::STAMP_W-1:0] tc_r, tc_nxt;
  logic [lfu_pkg::CFG_W-1:0]   cap_r, cap_nxt;

  // output register
  logic                        out_vld_r, out_vld_nxt;
  logic                        out_hit_r, out_hit_nxt;
  logic [lfu_pkg::VAL_W-1:0]   out_rv_r, out_rv_nxt;
  logic                        out_ev_r, out_ev_nxt;
  logic [lfu_pkg::KEY_W-1:0]   out_ekey_r, out_ekey_nxt;

  // ram ports
  logic                        ram_we, ram_re;
  logic [IDX_W-1:0]            ram_waddr, ram_raddr;
  lfu_pkg::entry_t             ram_wdata, ram_rent;
  logic [ENT_W-1:0]            ram_rdata;

  lfu_pkg::cmp_res_t           cmp;
  logic [CW-1:0]               cap_ext, cap_eff;
  logic                        issue, out_free, ent_vld;

  assign ram_rent = lfu_pkg::entry_t'(ram_rdata);

  lfu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  lfu_cmp u_cmp (
    .ent_key   (ram_rent.key),
    .req_key   (key_r),
    .ent_rank  ({ram_rent.count, ram_rent.stamp}),
    .best_rank (vic_rank_r),
    .res       (cmp)
  );

  // effective capacity, clamped to the table size
  always_comb begin
    cap_ext = CW'(cap_r);
    cap_eff = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;
  end

  // handshakes
  assign in_ch.ready  = (state_r == lfu_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.read_value  = out_rv_r;
  assign out_ch.evicted     = out_ev_r;
  assign out_ch.evicted_key = out_ekey_r;

  assign issue    = (scan_cnt_r != CNT_W'(CAPACITY));
  assign out_free = !out_vld_r || out_ch.ready;
  assign ent_vld  = vld_r[rd_idx_r];

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    scan_cnt_nxt  = scan_cnt_r;
    rd_pend_nxt   = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    found_nxt     = found_r;
    hit_idx_nxt   = hit_idx_r;
    hit_val_nxt   = hit_val_r;
    hit_cnt_nxt   = hit_cnt_r;
    have_vic_nxt  = have_vic_r;
    vic_idx_nxt   = vic_idx_r;
    vic_rank_nxt  = vic_rank_r;
    vic_key_nxt   = vic_key_r;
    free_have_nxt = free_have_r;
    free_idx_nxt  = free_idx_r;
    vld_nxt       = vld_r;
    occ_nxt       = occ_r;
    tc_nxt        = tc_r;
    cap_nxt       = cap_r;
    out_vld_nxt   = out_vld_r;
    out_hit_nxt   = out_hit_r;
    out_rv_nxt    = out_rv_r;
    out_ev_nxt    = out_ev_r;
    out_ekey_nxt  = out_ekey_r;
    ram_we        = 1'b0;
    ram_waddr     = free_idx_r;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = scan_cnt_r[IDX_W-1:0];

    // configuration write
    if (cfg_ch.valid) begin
      cap_nxt = cfg_ch.data;
    end

    // result taken
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      lfu_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt        = in_ch.op;
          key_nxt       = in_ch.key;
          val_nxt       = in_ch.value;
          scan_cnt_nxt  = '0;
          found_nxt     = 1'b0;
          have_vic_nxt  = 1'b0;
          free_have_nxt = 1'b0;
          state_nxt     = lfu_pkg::ST_SCAN;
        end
      end

      lfu_pkg::ST_SCAN: begin
        // issue one entry read per cycle
        if (issue) begin
          ram_re       = 1'b1;
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
          rd_pend_nxt  = 1'b1;
          rd_idx_nxt   = scan_cnt_r[IDX_W-1:0];
        end else begin
          state_nxt = lfu_pkg::ST_WRITE;
        end
        // evaluate the entry read in the previous cycle
        if (rd_pend_r) begin
          if (ent_vld) begin
            if (cmp.key_eq && !found_r) begin
              found_nxt   = 1'b1;
              hit_idx_nxt = rd_idx_r;
              hit_val_nxt = ram_rent.value;
              hit_cnt_nxt = ram_rent.count;
            end
            if (!have_vic_r || cmp.less) begin
              have_vic_nxt = 1'b1;
              vic_idx_nxt  = rd_idx_r;
              vic_rank_nxt = {ram_rent.count, ram_rent.stamp};
              vic_key_nxt  = ram_rent.key;
            end
          end else if (!free_have_r) begin
            free_have_nxt = 1'b1;
            free_idx_nxt  = rd_idx_r;
          end
        end
      end

      lfu_pkg::ST_WRITE: begin
        if (out_free) begin
          state_nxt    = lfu_pkg::ST_IDLE;
          out_vld_nxt  = 1'b1;
          out_hit_nxt  = 1'b0;
          out_rv_nxt   = '0;
          out_ev_nxt   = 1'b0;
          out_ekey_nxt = '0;
          ram_wdata.key   = key_r;
          ram_wdata.value = val_r;
          ram_wdata.count = lfu_pkg::COUNT_W'(1);
          ram_wdata.stamp = tc_r;
          if (found_r) begin
            // hit: bump count, restamp, update value on put
            out_hit_nxt = 1'b1;
            ram_we      = 1'b1;
            ram_waddr   = hit_idx_r;
            ram_wdata.count = (hit_cnt_r == lfu_pkg::COUNT_MAX) ?
                              hit_cnt_r : hit_cnt_r + lfu_pkg::COUNT_W'(1);
            if (op_r == lfu_pkg::OP_GET) begin
              out_rv_nxt      = hit_val_r;
              ram_wdata.value = hit_val_r;
            end
            tc_nxt = tc_r + lfu_pkg::STAMP_W'(1);
          end else if (op_r == lfu_pkg::OP_PUT && cap_eff != '0) begin
            if (CW'(occ_r) >= cap_eff) begin
              // full: replace the victim
              if (have_vic_r) begin
                out_ev_nxt   = 1'b1;
                out_ekey_nxt = vic_key_r;
                ram_we       = 1'b1;
                ram_waddr    = vic_idx_r;
                tc_nxt       = tc_r + lfu_pkg::STAMP_W'(1);
              end
            end else if (free_have_r) begin
              // room left: fill the lowest free slot
              ram_we              = 1'b1;
              ram_waddr           = free_idx_r;
              vld_nxt[free_idx_r] = 1'b1;
              occ_nxt             = occ_r + CNT_W'(1);
              tc_nxt              = tc_r + lfu_pkg::STAMP_W'(1);
            end
          end
        end
      end

      default: begin
        state_nxt = lfu_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lfu_pkg::ST_IDLE;
      rd_pend_r  <= 1'b0;
      vld_r      <= '0;
      occ_r      <= '0;
      tc_r       <= '0;
      cap_r      <= lfu_pkg::CAP_RESET;
      out_vld_r  <= 1'b0;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      rd_pend_r  <= rd_pend_nxt;
      vld_r      <= vld_nxt;
      occ_r      <= occ_nxt;
      tc_r       <= tc_nxt;
      cap_r      <= cap_nxt;
      out_vld_r  <= out_vld_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    rd_idx_r    <= rd_idx_nxt;
    found_r     <= found_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_val_r   <= hit_val_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    have_vic_r  <= have_vic_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_rank_r  <= vic_rank_nxt;
    vic_key_r   <= vic_key_nxt;
    free_have_r <= free_have_nxt;
    free_idx_r  <= free_idx_nxt;
    out_hit_r   <= out_hit_nxt;
    out_rv_r    <= out_rv_nxt;
    out_ev_r    <= out_ev_nxt;
    out_ekey_r  <= out_ekey_nxt;
  end

  // occupancy tracks the valid bits
  a_occ_matches: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == CNT_W'($countones(vld_r)))
    else $error("occupancy differs from number of valid entries");

  // an accepted request starts a scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == lfu_pkg::ST_SCAN && scan_cnt_r == '0))
    else $error("accepted request did not start a scan");

  // a new result only comes out of write-back
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == lfu_pkg::ST_WRITE)
    else $error("result raised outside write-back");

  // an eviction never reports a hit
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ev_r) |-> !out_hit_r)
    else $error("eviction reported together with a hit");

  // a held result is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> (out_vld_r && $stable(out_ekey_r) && $stable(out_rv_r)))
    else $error("stalled result changed");

endmodule
